[design/xoshiro_pkg.sv]
// Package for the xoshiro128 generator: item types, command and status structs,
// opcodes, command codes and the jump polynomials. No dependencies.
`timescale 1ns / 1ps

package xoshiro_pkg;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] bound;
      logic [1:0]  word_index;
      logic [31:0] word_value;
   } req_type;

   typedef struct packed {
      logic [31:0] value;
      logic        value_valid;
   } rsp_type;

   // Opcodes of an input item
   localparam logic [2:0] OP_RAW        = 3'd0;
   localparam logic [2:0] OP_BOUNDED    = 3'd1;
   localparam logic [2:0] OP_JUMP_SHORT = 3'd2;
   localparam logic [2:0] OP_JUMP_LONG  = 3'd3;
   localparam logic [2:0] OP_LOAD       = 3'd4;

   // Scrambler selection
   localparam logic [1:0] MODE_PLUS     = 2'd0;
   localparam logic [1:0] MODE_PLUSPLUS = 2'd1;
   localparam logic [1:0] MODE_STARSTAR = 2'd2;

   // Datapath commands
   localparam logic [3:0] CMD_NONE      = 4'd0;
   localparam logic [3:0] CMD_RAW       = 4'd1;
   localparam logic [3:0] CMD_LOAD      = 4'd2;
   localparam logic [3:0] CMD_EMPTY     = 4'd3;
   localparam logic [3:0] CMD_BND_START = 4'd4;
   localparam logic [3:0] CMD_BND_TRY   = 4'd5;
   localparam logic [3:0] CMD_JMP_START = 4'd6;
   localparam logic [3:0] CMD_JMP_STEP  = 4'd7;
   localparam logic [3:0] CMD_JMP_END   = 4'd8;

   typedef struct packed {
      logic [3:0] code;
      logic       poly_sel;
   } cmd_type;

   typedef struct packed {
      logic slot_free;
      logic bound_zero;
      logic bnd_hit;
      logic step_last;
   } status_type;

   localparam logic [31:0]  WORD_RESET    = 32'hf5f5f5f5;
   localparam logic [1:0]   MODE_RESET    = MODE_PLUSPLUS;

   // Jump polynomials, bit n taken at step n
   localparam logic [127:0] SHORT_POLY = {32'h77f2db5b, 32'h6fa035c3,
                                          32'hf542d2d3, 32'h8764000b};
   localparam logic [127:0] LONG_POLY  = {32'h1c580662, 32'hccf5a0ef,
                                          32'h0b6f099f, 32'hb523952e};

endpackage

[design/xoshiro_ctrl.sv]
// Controller of the xoshiro128 generator: sequences draws, bounded retries and jumps.
// Depends on xoshiro_pkg.
`timescale 1ns / 1ps

module xoshiro_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [2:0]              opcode,
   input  xoshiro_pkg::status_type status,
   output logic                    req_stall,
   output xoshiro_pkg::cmd_type    cmd
);
   import xoshiro_pkg::*;

   localparam logic [1:0] ST_IDLE     = 2'd0;
   localparam logic [1:0] ST_BOUNDED  = 2'd1;
   localparam logic [1:0] ST_JUMP     = 2'd2;
   localparam logic [1:0] ST_JUMP_END = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_stall = (state_ff != ST_IDLE) || !status.slot_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in      = state_ff;
      cmd.code      = CMD_NONE;
      cmd.poly_sel  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (opcode)
                  OP_RAW: begin
                     cmd.code = CMD_RAW;
                  end
                  OP_BOUNDED: begin
                     if (status.bound_zero) begin
                        cmd.code = CMD_RAW;
                     end else begin
                        cmd.code = CMD_BND_START;
                        state_in = ST_BOUNDED;
                     end
                  end
                  OP_JUMP_SHORT, OP_JUMP_LONG: begin
                     cmd.code      = CMD_JMP_START;
                     cmd.poly_sel  = (opcode == OP_JUMP_LONG);
                     state_in      = ST_JUMP;
                  end
                  OP_LOAD: begin
                     cmd.code = CMD_LOAD;
                  end
                  default: begin
                     cmd.code = CMD_EMPTY;
                  end
               endcase
            end
         end
         ST_BOUNDED: begin
            // hold off trying while the output register is blocked
            if (status.slot_free) begin
               cmd.code = CMD_BND_TRY;
               if (status.bnd_hit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_JUMP: begin
            cmd.code = CMD_JMP_STEP;
            if (status.step_last) begin
               state_in = ST_JUMP_END;
            end
         end
         ST_JUMP_END: begin
            if (status.slot_free) begin
               cmd.code = CMD_JMP_END;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[design/xoshiro_dp.sv]
// Datapath of the xoshiro128 generator: state words, jump accumulator, scramblers,
// bounded-draw compare and output register. Depends on xoshiro_pkg.
`timescale 1ns / 1ps

module xoshiro_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  xoshiro_pkg::req_type    req_data,
   input  xoshiro_pkg::cmd_type    cmd,
   output xoshiro_pkg::status_type status,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output xoshiro_pkg::rsp_type    rsp_data,
   input  logic                    csr_write_enable,
   input  logic [1:0]              csr_write_data
);
   import xoshiro_pkg::*;

   logic [31:0] gen_ff [4];
   logic [31:0] gen_in [4];
   logic [31:0] accum_ff [4];
   logic [31:0] accum_in [4];
   logic [31:0] next_words [4];
   logic [6:0]  jump_step_ff;
   logic [6:0]  jump_step_in;
   logic        long_ff;
   logic        long_in;
   logic [31:0] bound_ff;
   logic [31:0] bound_in;
   logic [4:0]  shift_ff;
   logic [4:0]  shift_in;
   logic [1:0]  mode_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   rsp_type     rsp_data_ff;
   rsp_type     rsp_data_in;
   logic [31:0] scrambled;
   logic [31:0] draw;
   logic        poly_bit;
   logic [31:0] t_word;
   logic [31:0] mix0;
   logic [31:0] mix1;
   logic [31:0] mix2;
   logic [31:0] mix3;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int k);
      rotl = (x << k) | (x >> (32 - k));
   endfunction

   // leading zero count of a nonzero bound
   function automatic logic [4:0] lead_zeros(input logic [31:0] b);
      logic [4:0] pos;
      pos = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (b[i]) begin
            pos = 5'(i);
         end
      end
      lead_zeros = 5'd31 - pos;
   endfunction

   function automatic logic [31:0] scramble(input logic [1:0] mode, input logic [31:0] s0,
                                            input logic [31:0] s1, input logic [31:0] s3);
      logic [31:0] x;
      logic [31:0] r;
      case (mode)
         MODE_PLUS: begin
            scramble = s0 + s3;
         end
         MODE_STARSTAR: begin
            x = s1 + (s1 << 2);
            r = rotl(x, 7);
            scramble = r + (r << 3);
         end
         default: begin
            scramble = rotl(s0 + s3, 7) + s0;
         end
      endcase
   endfunction

   // one xoshiro128 state step
   always_comb begin
      t_word = gen_ff[1] << 9;
      mix2   = gen_ff[2] ^ gen_ff[0];
      mix3   = gen_ff[3] ^ gen_ff[1];
      mix1   = gen_ff[1] ^ mix2;
      mix0   = gen_ff[0] ^ mix3;
      next_words[0] = mix0;
      next_words[1] = mix1;
      next_words[2] = mix2 ^ t_word;
      next_words[3] = rotl(mix3, 11);
   end

   assign scrambled = scramble(mode_ff, gen_ff[0], gen_ff[1], gen_ff[3]);
   assign draw      = scrambled >> shift_ff;
   assign poly_bit  = long_ff ? LONG_POLY[jump_step_ff] : SHORT_POLY[jump_step_ff];

   assign status.slot_free  = !rsp_valid_ff || !rsp_stall;
   assign status.bound_zero = (req_data.bound == 32'd0);
   assign status.bnd_hit    = (draw < bound_ff);
   assign status.step_last  = &jump_step_ff;

   always_comb begin
      gen_in       = gen_ff;
      accum_in     = accum_ff;
      jump_step_in = jump_step_ff;
      long_in      = long_ff;
      bound_in     = bound_ff;
      shift_in     = shift_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (cmd.code)
         CMD_RAW: begin
            gen_in       = next_words;
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{value: scrambled, value_valid: 1'b1};
         end
         CMD_LOAD: begin
            gen_in[req_data.word_index] = req_data.word_value;
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{value: 32'd0, value_valid: 1'b0};
         end
         CMD_EMPTY: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{value: 32'd0, value_valid: 1'b0};
         end
         CMD_BND_START: begin
            bound_in = req_data.bound;
            shift_in = lead_zeros(req_data.bound);
         end
         CMD_BND_TRY: begin
            gen_in = next_words;
            if (status.bnd_hit) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{value: draw, value_valid: 1'b1};
            end
         end
         CMD_JMP_START: begin
            for (int i = 0; i < 4; i++) begin
               accum_in[i] = 32'd0;
            end
            jump_step_in = 7'd0;
            long_in      = cmd.poly_sel;
         end
         CMD_JMP_STEP: begin
            if (poly_bit) begin
               for (int i = 0; i < 4; i++) begin
                  accum_in[i] = accum_ff[i] ^ gen_ff[i];
               end
            end
            gen_in       = next_words;
            jump_step_in = jump_step_ff + 7'd1;
         end
         CMD_JMP_END: begin
            gen_in       = accum_ff;
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{value: 32'd0, value_valid: 1'b0};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            gen_ff[i]   <= WORD_RESET;
            accum_ff[i] <= 32'd0;
         end
         jump_step_ff <= 7'd0;
         long_ff      <= 1'b0;
         mode_ff      <= MODE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         gen_ff       <= gen_in;
         accum_ff     <= accum_in;
         jump_step_ff <= jump_step_in;
         long_ff      <= long_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      bound_ff    <= bound_in;
      shift_ff    <= shift_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[design/xoshiro128_generator.sv]
// Top level of the xoshiro128 generator: joins controller and datapath.
// Depends on xoshiro_pkg, xoshiro_ctrl and xoshiro_dp.
`timescale 1ns / 1ps

// Usage
//   Request channel (req_valid, req_stall, req_data): one item per operation:
//   raw draw, bounded draw, short jump, long jump or load of one state word.
//   Response channel (rsp_valid, rsp_stall, rsp_data): exactly one item per
//   request, in order; value_valid marks a drawn number, other ops return zero.
//   CSR port (csr_write_enable, csr_write_data): scrambler select, 0 plus,
//   1 plusplus (also for code 3), 2 starstar; write only while idle.
// Sequencing and throughput
//   Raw draws, loads, unknown opcodes and bounded draws with a zero bound are
//   finished in the accept cycle, result in the next; one item per cycle
//   while no response is stalled. A bounded draw first latches the bound and
//   its shift, then tries while the output register is free (each attempt
//   advances the state); result after the hit. In a jump the single step unit
//   walks the 128 polynomial bits one per cycle before the state is replaced.
// Reset
//   Synchronous, active high: all state words become 0xf5f5f5f5, scrambler
//   becomes plusplus, the response register is emptied.
// Back-pressure
//   While rsp_stall holds a waiting item, req_stall is raised, bounded
//   attempts pause and a finished jump waits before writing its state.
module xoshiro128_generator (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  xoshiro_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output xoshiro_pkg::rsp_type rsp_data,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_write_data
);
   import xoshiro_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencing: what to do with the state each cycle
   xoshiro_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .opcode    (req_data.opcode),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   // state, scramblers, jump accumulation and the output register
   xoshiro_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

endmodule

[design/xoshiro_checker.sv]
// Port-level checks for the xoshiro128 generator, bound to the top level.
// Depends on xoshiro_pkg and xoshiro128_generator.
`timescale 1ns / 1ps

module xoshiro_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input xoshiro_pkg::req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input xoshiro_pkg::rsp_type rsp_data
);
   import xoshiro_pkg::*;

   // a waiting item is held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response item dropped or changed under stall");

   // non-draw results carry zero
   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.value_valid |-> rsp_data.value == 32'd0)
      else $error("non-draw result with nonzero value");

   // no request taken while the response slot is blocked
   a_block_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request accepted while response blocked");

   // a jump keeps the request side closed
   a_jump_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall &&
      (req_data.opcode == OP_JUMP_SHORT || req_data.opcode == OP_JUMP_LONG)
      |=> req_stall ##1 req_stall)
      else $error("request accepted during jump");

endmodule

bind xoshiro128_generator xoshiro_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[tb/xoshiro128_generator_tb.sv]
// Self-checking testbench for xoshiro128_generator: drives request items,
// predicts every response with its own generator model and checks it.
// Depends on xoshiro_pkg and the xoshiro128_generator design files only.
`timescale 1ns / 1ps

module xoshiro128_generator_tb;
   import xoshiro_pkg::*;

   // Opcodes that the block must ignore, and the spare scrambler code
   localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
   localparam logic [1:0] MODE_SPARE      = 2'd3;

   // Generous ceiling: every item waiting out both idle draws, plus jumps,
   // bounded retries and the long receiver hold, taken several times over
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 4;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_write_enable;
   logic [1:0] csr_write_data;

   xoshiro128_generator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Predictor state: the four generator words and the scrambler selection
   logic [31:0] gen_state [4];
   logic [1:0]  scrambler_sel;

   // Responses owed by the block, oldest first
   rsp_type awaited_results [$];

   int error_count = 0;
   int cycle_count = 0;
   int send_idle_max = 18;
   int recv_idle_max = 18;
   int hold_request = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Give up if the run hangs: a missing response ends here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int k);
      return (x << k) | (x >> (32 - k));
   endfunction

   // Advance the generator by one step and return the scrambled word
   // formed from the words as they stood before the step
   function automatic logic [31:0] step_state();
      logic [31:0] s0, s1, s2, s3, t, scaled, word;
      s0 = gen_state[0];
      s1 = gen_state[1];
      s2 = gen_state[2];
      s3 = gen_state[3];
      case (scrambler_sel)
         MODE_PLUS: begin
            word = s0 + s3;
         end
         MODE_STARSTAR: begin
            scaled = s1 * 32'd5;
            word = rotl32(scaled, 7) * 32'd9;
         end
         // plusplus, and the spare code which behaves the same
         default: begin
            word = rotl32(s0 + s3, 7) + s0;
         end
      endcase
      t = s1 << 9;
      s2 ^= s0;
      s3 ^= s1;
      s1 ^= s2;
      s0 ^= s3;
      s2 ^= t;
      s3 = rotl32(s3, 11);
      gen_state[0] = s0;
      gen_state[1] = s1;
      gen_state[2] = s2;
      gen_state[3] = s3;
      return word;
   endfunction

   // Shift draws down to the bit length of the bound, reject until below it
   function automatic logic [31:0] bounded_draw(input logic [31:0] bound);
      int msb;
      logic [31:0] r;
      if (bound == 32'd0)
         return step_state();
      msb = 0;
      for (int i = 0; i < 32; i++)
         if (bound[i])
            msb = i;
      do
         r = step_state() >> (31 - msb);
      while (r >= bound);
      return r;
   endfunction

   // Walk the 128 polynomial bits, folding in the state at every one bit,
   // then replace the state with the accumulation
   function automatic void jump_state(input logic [127:0] poly);
      logic [31:0] acc [4];
      for (int w = 0; w < 4; w++)
         acc[w] = 32'd0;
      for (int n = 0; n < 128; n++) begin
         if (poly[n])
            for (int w = 0; w < 4; w++)
               acc[w] ^= gen_state[w];
         void'(step_state());
      end
      for (int w = 0; w < 4; w++)
         gen_state[w] = acc[w];
   endfunction

   function automatic rsp_type predict_response(input req_type item);
      rsp_type r;
      r.value = 32'd0;
      r.value_valid = 1'b0;
      case (item.opcode)
         OP_RAW: begin
            r.value = step_state();
            r.value_valid = 1'b1;
         end
         OP_BOUNDED: begin
            r.value = bounded_draw(item.bound);
            r.value_valid = 1'b1;
         end
         OP_JUMP_SHORT: jump_state(SHORT_POLY);
         OP_JUMP_LONG:  jump_state(LONG_POLY);
         OP_LOAD:       gen_state[item.word_index] = item.word_value;
         default: ;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Item builders
   // ---------------------------------------------------------------------

   function automatic req_type random_fields();
      req_type r;
      r.opcode = 3'($urandom);
      r.bound = $urandom;
      r.word_index = 2'($urandom);
      r.word_value = $urandom;
      return r;
   endfunction

   function automatic req_type make_request(input logic [2:0] opcode,
                                            input logic [31:0] bound,
                                            input logic [1:0] word_index,
                                            input logic [31:0] word_value);
      req_type r;
      r.opcode = opcode;
      r.bound = bound;
      r.word_index = word_index;
      r.word_value = word_value;
      return r;
   endfunction

   // Mostly draws, some loads to scatter the state, the odd jump and a few
   // opcodes that the block should ignore
   function automatic req_type random_request();
      req_type r;
      int pick;
      r = random_fields();
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         r.opcode = OP_RAW;
      end else if (pick < 78) begin
         r.opcode = OP_BOUNDED;
         if ($urandom_range(0, 9) == 0)
            r.bound = 32'd0;
         else
            r.bound = $urandom >> $urandom_range(0, 31);
      end else if (pick < 80) begin
         r.opcode = $urandom_range(0, 1) ? OP_JUMP_SHORT : OP_JUMP_LONG;
      end else if (pick < 96) begin
         r.opcode = OP_LOAD;
      end else begin
         r.opcode = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Idle for a drawn number of cycles, then hold the item until accepted
   // and record what the block owes for it
   task automatic offer_request(input req_type item);
      int gap;
      gap = $urandom_range(0, send_idle_max);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_data <= random_fields();
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do
         @(posedge clock);
      while (req_stall);
      awaited_results.push_back(predict_response(item));
   endtask

   // Drop valid and wait until every owed response has come back
   task automatic wait_until_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_scrambler(input logic [1:0] mode);
      wait_until_idle();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= mode;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      scrambler_sel = mode;
   endtask

   // ---------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------

   // Stall before each item for a drawn number of cycles, or for the long
   // hold when one has been asked for, then release until an item passes
   initial begin : response_sink
      int wait_cycles;
      rsp_stall = 1'b0;
      forever begin
         if (hold_request > 0) begin
            wait_cycles = hold_request;
            hold_request = 0;
         end else begin
            wait_cycles = $urandom_range(0, recv_idle_max);
         end
         @(negedge clock);
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do
            @(posedge clock);
         while (!rsp_valid);
      end
   end

   // Compare every accepted response with the oldest owed one
   always @(posedge clock) begin : response_check
      rsp_type owed;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            $error("unexpected response: value %h, value_valid %b",
                   rsp_data.value, rsp_data.value_valid);
            error_count++;
         end else begin
            owed = awaited_results.pop_front();
            if (rsp_data.value !== owed.value) begin
               $error("value: expected %h, actual %h", owed.value, rsp_data.value);
               error_count++;
            end
            if (rsp_data.value_valid !== owed.value_valid) begin
               $error("value_valid: expected %b, actual %b",
                      owed.value_valid, rsp_data.value_valid);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Raw draw and bounded draws across the extremes of the bound
   task automatic test_bound_extremes();
      offer_request(make_request(OP_RAW, 32'd0, 2'd0, 32'd0));
      offer_request(make_request(OP_BOUNDED, 32'd0, 2'd0, 32'd0));
      offer_request(make_request(OP_BOUNDED, 32'd1, 2'd0, 32'd0));
      offer_request(make_request(OP_BOUNDED, 32'd2, 2'd0, 32'd0));
      offer_request(make_request(OP_BOUNDED, 32'd3, 2'd0, 32'd0));
      offer_request(make_request(OP_BOUNDED, 32'h7fffffff, 2'd0, 32'd0));
      offer_request(make_request(OP_BOUNDED, 32'h80000000, 2'd0, 32'd0));
      offer_request(make_request(OP_BOUNDED, 32'h80000001, 2'd0, 32'd0));
      offer_request(make_request(OP_BOUNDED, 32'hffffffff, 2'd3, 32'hffffffff));
   endtask

   // Loads at both ends of index and value, each jump followed by a draw
   task automatic test_loads_and_jumps();
      offer_request(make_request(OP_LOAD, 32'd0, 2'd3, 32'hffffffff));
      offer_request(make_request(OP_LOAD, 32'hffffffff, 2'd0, 32'd0));
      offer_request(make_request(OP_RAW, 32'd0, 2'd0, 32'd0));
      offer_request(make_request(OP_JUMP_SHORT, 32'd0, 2'd0, 32'd0));
      offer_request(make_request(OP_RAW, 32'd0, 2'd0, 32'd0));
      offer_request(make_request(OP_JUMP_LONG, 32'd0, 2'd0, 32'd0));
      offer_request(make_request(OP_RAW, 32'd0, 2'd0, 32'd0));
   endtask

   // All-zero state, unused opcodes, then scatter the state again
   task automatic test_special_cases();
      req_type r;
      for (int w = 0; w < 4; w++)
         offer_request(make_request(OP_LOAD, 32'd0, w[1:0], 32'd0));
      offer_request(make_request(OP_RAW, 32'd0, 2'd0, 32'd0));
      offer_request(make_request(OP_BOUNDED, 32'd5, 2'd0, 32'd0));
      offer_request(make_request(OP_BOUNDED, 32'd0, 2'd0, 32'd0));
      for (logic [2:0] op = OP_UNUSED_FIRST; op >= OP_UNUSED_FIRST; op++) begin
         r = random_fields();
         r.opcode = op;
         offer_request(r);
      end
      for (int w = 0; w < 4; w++)
         offer_request(make_request(OP_LOAD, 32'd0, w[1:0], $urandom));
   endtask

   // Every scrambler code, the spare one included, with draws under each
   task automatic test_scramblers();
      logic [1:0] modes [4];
      modes = '{MODE_PLUS, MODE_STARSTAR, MODE_SPARE, MODE_PLUSPLUS};
      for (int m = 0; m < 4; m++) begin
         set_scrambler(modes[m]);
         repeat (3) offer_request(make_request(OP_RAW, 32'd0, 2'd0, 32'd0));
         offer_request(make_request(OP_BOUNDED, $urandom, 2'd0, 32'd0));
      end
   endtask

   // Hold the response side for a long stretch while items keep coming,
   // so the block fills and stalls its input; then pause the sender
   task automatic test_back_pressure();
      wait_until_idle();
      send_idle_max = 0;
      recv_idle_max = 0;
      hold_request = 80;
      repeat (30) offer_request(random_request());
      wait_until_idle();
      repeat (10) offer_request(random_request());
      wait_until_idle();
      send_idle_max = 18;
      recv_idle_max = 18;
   endtask

   // Random items in phases, each with its own scrambler and idle pattern
   task automatic test_random_mix();
      logic [1:0] phase_mode [8];
      phase_mode = '{MODE_PLUS, MODE_STARSTAR, MODE_PLUSPLUS, MODE_SPARE,
                     MODE_STARSTAR, MODE_PLUS, MODE_PLUSPLUS, MODE_STARSTAR};
      for (int p = 0; p < 8; p++) begin
         set_scrambler(phase_mode[p]);
         case (p % 4)
            0: begin
               send_idle_max = 0;
               recv_idle_max = 0;
            end
            1: begin
               send_idle_max = 18;
               recv_idle_max = 18;
            end
            2: begin
               send_idle_max = 0;
               recv_idle_max = 18;
            end
            default: begin
               send_idle_max = 18;
               recv_idle_max = 0;
            end
         endcase
         repeat (185) offer_request(random_request());
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write_enable = 1'b0;
      csr_write_data = MODE_RESET;
      scrambler_sel = MODE_RESET;
      for (int w = 0; w < 4; w++)
         gen_state[w] = WORD_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_bound_extremes();
      test_loads_and_jumps();
      test_special_cases();
      test_scramblers();
      test_back_pressure();
      test_random_mix();

      wait_until_idle();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
